/* rtl/pfvp_pkg.sv */
`default_nettype none

package pfvp_pkg;

    // Stream byte layout
    localparam int BYTE_W       = 8;
    localparam int FIELD_W      = 5;
    localparam int WIRE_W       = 3;
    localparam int VALUE_W      = 32;
    localparam int GROUP_W      = 3;

    // Varint group payload and continuation bit (0x7f / 0x80)
    localparam int GROUP_BITS   = 7;
    localparam int CONT_BIT     = 7;

    // Groups that still land in the 32-bit value
    localparam logic [GROUP_W-1:0] MAX_GROUPS = 3'd5;

    // Wire types the block can be asked to match
    localparam logic [WIRE_W-1:0] WIRE_VARINT = 3'd0;
    localparam logic [WIRE_W-1:0] WIRE_LEN    = 3'd2;

    // Channel packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic                 matched;
        logic [FIELD_W-1:0]   field_seen;
        logic [WIRE_W-1:0]    wire_seen;
        logic [VALUE_W-1:0]   value;
        logic                 overflow;
    } result_t;

endpackage

`default_nettype wire

/* rtl/pfvp_decode.sv */
`default_nettype none

module pfvp_decode
    import pfvp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic [FIELD_W-1:0] want_field,
    input  wire logic               want_message,
    output logic                    res_valid,
    output result_t                 res
);

    logic                 in_varint_reg,   in_varint_next;
    logic [VALUE_W-1:0]   accum_reg,       accum_next;
    logic [GROUP_W-1:0]   group_cnt_reg,   group_cnt_next;
    logic                 ovf_reg,         ovf_next;
    logic [FIELD_W-1:0]   tag_field_reg,   tag_field_next;
    logic [WIRE_W-1:0]    tag_wire_reg,    tag_wire_next;

    logic [FIELD_W-1:0]   byte_field;
    logic [WIRE_W-1:0]    byte_wire;
    logic [WIRE_W-1:0]    want_wire;
    logic [VALUE_W-1:0]   grp_ext;
    logic [VALUE_W-1:0]   grp_shifted;
    logic [VALUE_W-1:0]   accum_upd;
    logic                 ovf_upd;

    assign byte_field = data_byte[BYTE_W-1:WIRE_W];
    assign byte_wire  = data_byte[WIRE_W-1:0];
    assign want_wire  = want_message ? WIRE_LEN : WIRE_VARINT;
    assign grp_ext    = VALUE_W'(data_byte[GROUP_BITS-1:0]);

    // Place the group at 7 * group count; the fifth group loses its top bits
    always_comb begin
        unique case (group_cnt_reg)
            3'd0:    grp_shifted = grp_ext;
            3'd1:    grp_shifted = grp_ext << GROUP_BITS;
            3'd2:    grp_shifted = grp_ext << (2 * GROUP_BITS);
            3'd3:    grp_shifted = grp_ext << (3 * GROUP_BITS);
            3'd4:    grp_shifted = grp_ext << (4 * GROUP_BITS);
            default: grp_shifted = '0;
        endcase
    end

    always_comb begin
        in_varint_next = in_varint_reg;
        accum_next     = accum_reg;
        group_cnt_next = group_cnt_reg;
        ovf_next       = ovf_reg;
        tag_field_next = tag_field_reg;
        tag_wire_next  = tag_wire_reg;
        res_valid      = 1'b0;
        res            = '0;
        accum_upd      = accum_reg;
        ovf_upd        = ovf_reg;

        if (group_cnt_reg < MAX_GROUPS) begin
            accum_upd = accum_reg | grp_shifted;
        end else begin
            ovf_upd = 1'b1;
        end

        if (step_en) begin
            if (!in_varint_reg) begin
                if (byte_field == want_field && byte_wire == want_wire) begin
                    in_varint_next = 1'b1;
                    accum_next     = '0;
                    group_cnt_next = '0;
                    ovf_next       = 1'b0;
                    tag_field_next = byte_field;
                    tag_wire_next  = byte_wire;
                end else begin
                    res_valid      = 1'b1;
                    res.matched    = 1'b0;
                    res.field_seen = byte_field;
                    res.wire_seen  = byte_wire;
                end
            end else if (!data_byte[CONT_BIT]) begin
                res_valid      = 1'b1;
                res.matched    = 1'b1;
                res.field_seen = tag_field_reg;
                res.wire_seen  = tag_wire_reg;
                res.value      = accum_upd;
                res.overflow   = ovf_upd;
                in_varint_next = 1'b0;
                accum_next     = '0;
                group_cnt_next = '0;
                ovf_next       = 1'b0;
            end else begin
                accum_next = accum_upd;
                ovf_next   = ovf_upd;
                if (group_cnt_reg < MAX_GROUPS) begin
                    group_cnt_next = group_cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_varint_reg <= 1'b0;
            accum_reg     <= '0;
            group_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            tag_field_reg <= '0;
            tag_wire_reg  <= '0;
        end else begin
            in_varint_reg <= in_varint_next;
            accum_reg     <= accum_next;
            group_cnt_reg <= group_cnt_next;
            ovf_reg       <= ovf_next;
            tag_field_reg <= tag_field_next;
            tag_wire_reg  <= tag_wire_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pfvp_out_stage.sv */
`default_nettype none

module pfvp_out_stage
    import pfvp_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   in_valid,
    input  wire result_t in_res,
    output logic        can_accept,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg,   res_next;

    // Room for a new result when empty or when the held one leaves now
    assign can_accept = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (can_accept) begin
            valid_next = in_valid;
            if (in_valid) begin
                res_next = in_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

/* rtl/protobuf_field_varint_parser.sv */
`default_nettype none
// Protobuf tag + varint decoder for one expected field.
// Input channel (s_*): one stream byte per item, together with the field
// number and wire kind (varint or length-delimited) that the next tag must
// carry. Those two only matter on a tag byte.
// Result channel (m_*): one item per mismatching tag, and one per finished
// varint after a matching tag. m_tuser is the match flag; on a mismatch the
// value and overflow bits are zero and the block waits for the next tag.
// Varints gather 7-bit groups little-endian; past five groups the bits drop
// and the overflow bit is set.
// A result is registered onto m_* in the cycle after the byte that ends it.
// Throughput: one byte per cycle while s_tready is high, set by the single
// result register. Decoder state updates in the cycle the byte is taken.
// Stall: while a result waits and m_tready is low, s_tready drops and the
// byte stream holds; s_tready returns in the cycle the result is taken.
// Reset: aresetn low (synchronous) clears the result register and sends the
// decoder back to expecting a tag.

module protobuf_field_varint_parser
    import pfvp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [7:0] data_byte, [12:8] want_field, [13] want_message, [15:14] zero
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [4:0] field_seen, [7:5] wire_seen, [39:8] value, [40] overflow,
    // [47:41] zero
    output logic [M_TDATA_W-1:0]        m_tdata,
    // [0] matched
    output logic                        m_tuser
);

    logic    step_en;
    logic    dec_valid;
    result_t dec_res;
    result_t out_res;

    // Advance the decoder only on an accepted byte
    assign step_en = s_tvalid && s_tready;

    pfvp_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .data_byte    (s_tdata[BYTE_W-1:0]),
        .want_field   (s_tdata[BYTE_W+FIELD_W-1:BYTE_W]),
        .want_message (s_tdata[BYTE_W+FIELD_W]),
        .res_valid    (dec_valid),
        .res          (dec_res)
    );

    // Hold the result until taken; bytes keep flowing while it moves
    pfvp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (dec_valid),
        .in_res     (dec_res),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tuser = out_res.matched;
    assign m_tdata = {7'b0, out_res.overflow, out_res.value,
                      out_res.wire_seen, out_res.field_seen};

endmodule

`default_nettype wire

/* rtl/pfvp_checker.sv */
`default_nettype none

module pfvp_checker
    import pfvp_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tready,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,
    input  wire logic                   m_tuser
);

    // A stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Mismatch carries zero value and no overflow
    a_mismatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[M_TDATA_W-1:FIELD_W+WIRE_W] == '0)
        else $error("mismatch result with value or overflow set");

    // A match only on wire types 0 and 2
    a_wire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata[FIELD_W+WIRE_W-1:FIELD_W] == WIRE_VARINT ||
             m_tdata[FIELD_W+WIRE_W-1:FIELD_W] == WIRE_LEN))
        else $error("matched result with unexpected wire type");

    // An empty result register never blocks the byte stream
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

endmodule

bind protobuf_field_varint_parser pfvp_checker u_pfvp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
